/* rtl/liquidity_latency_route_select_assert.svh */
// Assertion macros used by the route selector back end.
`ifndef LIQUIDITY_LATENCY_ROUTE_SELECT_ASSERT_SVH
`define LIQUIDITY_LATENCY_ROUTE_SELECT_ASSERT_SVH
`ifndef SYNTHESIS
`define LLRS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");
`define LLRS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define LLRS_ASSERT(lbl, prop)
`define LLRS_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

/* rtl/llrs_pkg.sv */
// Package with the types, constants and helpers of the route selector.
`timescale 1ns / 1ps
package llrs_pkg;

    localparam int NUM_GATEWAYS = 8;
    localparam int GW_IDX_W     = (NUM_GATEWAYS > 1) ? $clog2(NUM_GATEWAYS) : 1;
    localparam int GW_CNT_W     = $clog2(NUM_GATEWAYS + 1);

    localparam int OP_W       = 2;
    localparam int GW_W       = 3;
    localparam int IN_DEPTH_W = 48;
    localparam int DEPTH_W    = 47;
    localparam int RTT_W      = 32;
    localparam int TAG_W      = 32;
    localparam int CNT_W      = 32;

    localparam int DEPTH_LO_W = 32;
    localparam int DEPTH_HI_W = DEPTH_W - DEPTH_LO_W;
    localparam int PROD_LO_W  = DEPTH_LO_W + RTT_W;
    localparam int PROD_HI_W  = DEPTH_HI_W + RTT_W;
    localparam int PROD_W     = DEPTH_W + RTT_W;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 72;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_DEPTH = 2'd0,
        OP_LINK  = 2'd1,
        OP_ROUTE = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_DEPTH,
        KIND_LINK,
        KIND_ROUTE
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CMP,
        ST_OUT
    } t_back_state;

    // Input payload, gateway in the lowest bits.
    typedef struct packed {
        logic [3:0]            pad;
        logic [TAG_W-1:0]      order_tag;
        logic                  link_up;
        logic [RTT_W-1:0]      rtt_ns;
        logic [IN_DEPTH_W-1:0] depth;
        logic [GW_W-1:0]       gateway;
    } t_s_data;

    // Result payload, chosen gateway in the lowest bits.
    typedef struct packed {
        logic [4:0]       pad;
        logic [CNT_W-1:0] dropped_total;
        logic [TAG_W-1:0] order_tag_out;
        logic [GW_W-1:0]  chosen_gateway;
    } t_m_data;

    typedef struct packed {
        t_kind                kind;
        logic [GW_IDX_W-1:0]  gw;
        logic [DEPTH_W-1:0]   depth;
        logic [RTT_W-1:0]     rtt;
        logic                 link_up;
        logic [TAG_W-1:0]     tag;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // An unmeasured round-trip time counts as one nanosecond.
    function automatic logic [RTT_W-1:0] eff_rtt(input logic [RTT_W-1:0] r);
        return (r == '0) ? RTT_W'(1) : r;
    endfunction

endpackage

/* rtl/llrs_front.sv */
// Front end: accepts input transfers, decodes and clamps them into commands.
`timescale 1ns / 1ps
module llrs_front (
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [llrs_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [llrs_pkg::OP_W-1:0]        s_tuser,
    input  llrs_pkg::t_q_status              i_q_status,
    output logic                             o_push,
    output llrs_pkg::t_cmd                   o_cmd
);

    llrs_pkg::t_s_data data;
    llrs_pkg::t_op     op;
    logic              gw_ok;
    logic              keep;

    assign data = llrs_pkg::t_s_data'(s_tdata);
    assign op   = llrs_pkg::t_op'(s_tuser);
    assign gw_ok = int'(data.gateway) < llrs_pkg::NUM_GATEWAYS;

    always_comb begin
        case (op)
            llrs_pkg::OP_DEPTH: keep = gw_ok;
            llrs_pkg::OP_LINK:  keep = gw_ok;
            llrs_pkg::OP_ROUTE: keep = 1'b1;
            default:            keep = 1'b0;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (op)
            llrs_pkg::OP_DEPTH: o_cmd.kind = llrs_pkg::KIND_DEPTH;
            llrs_pkg::OP_LINK:  o_cmd.kind = llrs_pkg::KIND_LINK;
            default:            o_cmd.kind = llrs_pkg::KIND_ROUTE;
        endcase
        o_cmd.gw = llrs_pkg::GW_IDX_W'(data.gateway);
        // Negative or zero depth is stored as one.
        if (data.depth[llrs_pkg::IN_DEPTH_W-1] || (data.depth == '0)) begin
            o_cmd.depth = llrs_pkg::DEPTH_W'(1);
        end else begin
            o_cmd.depth = data.depth[llrs_pkg::DEPTH_W-1:0];
        end
        o_cmd.rtt     = data.rtt_ns;
        o_cmd.link_up = data.link_up;
        o_cmd.tag     = data.order_tag;
    end

    // Unused ops and out-of-range updates are taken and dropped here.
    assign s_tready = !i_q_status.full;
    assign o_push   = s_tvalid && s_tready && keep;

endmodule

/* rtl/llrs_fifo.sv */
// Command queue between the front end and the execution back end.
`timescale 1ns / 1ps
module llrs_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  llrs_pkg::t_cmd       i_cmd,
    input  logic                 i_pop,
    output llrs_pkg::t_cmd       o_cmd,
    output llrs_pkg::t_q_status  o_status
);

    llrs_pkg::t_cmd                    r_mem [llrs_pkg::FIFO_DEPTH];
    logic [llrs_pkg::FIFO_PTR_W-1:0]   r_wr;
    logic [llrs_pkg::FIFO_PTR_W-1:0]   r_rd;
    logic [llrs_pkg::FIFO_CNT_W-1:0]   r_count;
    logic                              do_push;
    logic                              do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == llrs_pkg::FIFO_CNT_W'(llrs_pkg::FIFO_DEPTH));
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

/* rtl/llrs_back.sv */
// Back end: gateway tables, sequential best-score scan and result register.
`timescale 1ns / 1ps
`include "liquidity_latency_route_select_assert.svh"
module llrs_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_empty,
    input  llrs_pkg::t_cmd                   i_cmd,
    output logic                             o_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [llrs_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tuser
);

    localparam int GW_IDX_W = llrs_pkg::GW_IDX_W;
    localparam int GW_CNT_W = llrs_pkg::GW_CNT_W;

    logic [llrs_pkg::DEPTH_W-1:0] r_depth [llrs_pkg::NUM_GATEWAYS];
    logic [llrs_pkg::RTT_W-1:0]   r_rtt   [llrs_pkg::NUM_GATEWAYS];
    logic                         r_link  [llrs_pkg::NUM_GATEWAYS];

    llrs_pkg::t_back_state r_state;
    llrs_pkg::t_back_state n_state;
    logic [GW_CNT_W-1:0]   r_idx;
    logic                  r_found;
    logic [GW_IDX_W-1:0]   r_best;
    logic [llrs_pkg::DEPTH_W-1:0]   r_best_depth;
    logic [llrs_pkg::RTT_W-1:0]     r_best_rtt;
    logic [llrs_pkg::TAG_W-1:0]     r_tag;
    logic [llrs_pkg::PROD_LO_W-1:0] r_l_lo;
    logic [llrs_pkg::PROD_HI_W-1:0] r_l_hi;
    logic [llrs_pkg::PROD_LO_W-1:0] r_r_lo;
    logic [llrs_pkg::PROD_HI_W-1:0] r_r_hi;
    logic [llrs_pkg::CNT_W-1:0]     r_drop;
    logic [llrs_pkg::CNT_W-1:0]     n_drop;
    logic                           r_out_valid;
    llrs_pkg::t_m_data              r_out_data;
    logic                           r_out_routed;

    logic [GW_IDX_W-1:0]            idx_cur;
    logic                           scan_end;
    logic [llrs_pkg::DEPTH_W-1:0]   cur_depth;
    logic [llrs_pkg::RTT_W-1:0]     cur_rtt;
    logic                           cur_link;
    logic [llrs_pkg::PROD_LO_W-1:0] l_lo_p;
    logic [llrs_pkg::PROD_HI_W-1:0] l_hi_p;
    logic [llrs_pkg::PROD_LO_W-1:0] r_lo_p;
    logic [llrs_pkg::PROD_HI_W-1:0] r_hi_p;
    logic [llrs_pkg::PROD_W-1:0]    l_full;
    logic [llrs_pkg::PROD_W-1:0]    r_full;
    logic                           beats;
    logic                           out_free;

    logic wr_depth;
    logic wr_link;
    logic start_route;
    logic take_first;
    logic skip_step;
    logic mul_en;
    logic cmp_en;
    logic out_load;

    assign idx_cur   = r_idx[GW_IDX_W-1:0];
    assign scan_end  = (r_idx == GW_CNT_W'(llrs_pkg::NUM_GATEWAYS));
    assign cur_depth = r_depth[idx_cur];
    assign cur_rtt   = llrs_pkg::eff_rtt(r_rtt[idx_cur]);
    assign cur_link  = r_link[idx_cur];
    assign out_free  = !r_out_valid || m_tready;

    // Each 47 x 32 product is split at bit 32 of the depth into two partial products.
    assign l_lo_p = cur_depth[llrs_pkg::DEPTH_LO_W-1:0] * r_best_rtt;
    assign l_hi_p = cur_depth[llrs_pkg::DEPTH_W-1:llrs_pkg::DEPTH_LO_W] * r_best_rtt;
    assign r_lo_p = r_best_depth[llrs_pkg::DEPTH_LO_W-1:0] * cur_rtt;
    assign r_hi_p = r_best_depth[llrs_pkg::DEPTH_W-1:llrs_pkg::DEPTH_LO_W] * cur_rtt;

    assign l_full = {r_l_hi, {llrs_pkg::DEPTH_LO_W{1'b0}}} + llrs_pkg::PROD_W'(r_l_lo);
    assign r_full = {r_r_hi, {llrs_pkg::DEPTH_LO_W{1'b0}}} + llrs_pkg::PROD_W'(r_r_lo);
    assign beats  = l_full > r_full;

    assign n_drop = (!r_found && (r_drop != '1)) ? r_drop + 1'b1 : r_drop;

    always_comb begin
        n_state = r_state;
        case (r_state)
            llrs_pkg::ST_IDLE: begin
                if (!i_q_empty && (i_cmd.kind == llrs_pkg::KIND_ROUTE)) begin
                    n_state = llrs_pkg::ST_SCAN;
                end
            end
            llrs_pkg::ST_SCAN: begin
                if (scan_end) begin
                    n_state = llrs_pkg::ST_OUT;
                end else if (cur_link && r_found) begin
                    n_state = llrs_pkg::ST_CMP;
                end
            end
            llrs_pkg::ST_CMP: begin
                n_state = llrs_pkg::ST_SCAN;
            end
            llrs_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = llrs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = llrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        wr_depth    = 1'b0;
        wr_link     = 1'b0;
        start_route = 1'b0;
        take_first  = 1'b0;
        skip_step   = 1'b0;
        mul_en      = 1'b0;
        cmp_en      = 1'b0;
        out_load    = 1'b0;
        case (r_state)
            llrs_pkg::ST_IDLE: begin
                o_pop = !i_q_empty;
                if (!i_q_empty) begin
                    case (i_cmd.kind)
                        llrs_pkg::KIND_DEPTH: wr_depth = 1'b1;
                        llrs_pkg::KIND_LINK:  wr_link = 1'b1;
                        default:              start_route = 1'b1;
                    endcase
                end
            end
            llrs_pkg::ST_SCAN: begin
                if (!scan_end) begin
                    skip_step  = !cur_link;
                    take_first = cur_link && !r_found;
                    mul_en     = cur_link && r_found;
                end
            end
            llrs_pkg::ST_CMP: begin
                cmp_en = 1'b1;
            end
            llrs_pkg::ST_OUT: begin
                out_load = out_free;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= llrs_pkg::ST_IDLE;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_drop      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < llrs_pkg::NUM_GATEWAYS; i++) begin
                r_depth[i] <= llrs_pkg::DEPTH_W'(1);
                r_rtt[i]   <= '0;
                r_link[i]  <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (wr_depth) begin
                r_depth[i_cmd.gw] <= i_cmd.depth;
            end
            if (wr_link) begin
                r_rtt[i_cmd.gw]  <= i_cmd.rtt;
                r_link[i_cmd.gw] <= i_cmd.link_up;
            end
            if (start_route) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else if (skip_step || take_first || cmp_en) begin
                r_idx <= r_idx + 1'b1;
            end
            if (take_first) begin
                r_found <= 1'b1;
            end
            if (out_load) begin
                r_drop      <= n_drop;
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_route) begin
            r_tag <= i_cmd.tag;
        end
        if (take_first || (cmp_en && beats)) begin
            r_best       <= idx_cur;
            r_best_depth <= cur_depth;
            r_best_rtt   <= cur_rtt;
        end
        if (mul_en) begin
            r_l_lo <= l_lo_p;
            r_l_hi <= l_hi_p;
            r_r_lo <= r_lo_p;
            r_r_hi <= r_hi_p;
        end
        if (out_load) begin
            r_out_data.pad            <= '0;
            r_out_data.dropped_total  <= n_drop;
            r_out_data.order_tag_out  <= r_tag;
            r_out_data.chosen_gateway <= r_found ? llrs_pkg::GW_W'(r_best) : '0;
            r_out_routed              <= r_found;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;
    assign m_tuser  = r_out_routed;

    `LLRS_ASSERT(a_idx_bound, r_idx <= GW_CNT_W'(llrs_pkg::NUM_GATEWAYS))
    `LLRS_ASSERT_IMPL(a_cmp_after_scan, r_state == llrs_pkg::ST_CMP, $past(r_state) == llrs_pkg::ST_SCAN)
    `LLRS_ASSERT_IMPL(a_cmp_has_best, r_state == llrs_pkg::ST_CMP, r_found)
    `LLRS_ASSERT_IMPL(a_out_from_result, $rose(r_out_valid), $past(r_state) == llrs_pkg::ST_OUT)

endmodule

/* rtl/liquidity_latency_route_select.sv */
// Top level of the liquidity and latency based gateway route selector.
//
//  Channel   Dir  tdata (low bit up)                              tuser
//  s_*       in   gateway[2:0] depth[50:3] rtt_ns[82:51]          op[1:0]
//                 link_up[83] order_tag[115:84]
//  m_*       out  chosen_gateway[2:0] order_tag_out[34:3]         routed
//                 dropped_total[66:35]
//
// Updates are applied in the back end once they reach the head of the queue.
// A route is dequeued, then each gateway is visited in turn in the scan state
// (each connected gateway after the first also passes the compare state of the
// single cross-multiply compare unit); the scan is closed and the result register
// loaded. The load waits while the previous result is still held on the output.
// The four-entry queue keeps input transfers flowing while a scan runs, until it
// is full. Reset is synchronous and active low and restores depth 1, rtt 0 and
// link down for every gateway and clears the drop count.
`timescale 1ns / 1ps
module liquidity_latency_route_select (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // gateway, depth, rtt_ns, link_up, order_tag
    input  logic [llrs_pkg::S_TDATA_W-1:0]   s_tdata,
    // op
    input  logic [llrs_pkg::OP_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // chosen_gateway, order_tag_out, dropped_total
    output logic [llrs_pkg::M_TDATA_W-1:0]   m_tdata,
    // routed
    output logic                             m_tuser
);

    llrs_pkg::t_q_status q_status;
    llrs_pkg::t_cmd      push_cmd;
    llrs_pkg::t_cmd      head_cmd;
    logic                push;
    logic                pop;

    llrs_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    llrs_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    llrs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_status.empty),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* tb/sv/liquidity_latency_route_select_tb.sv */
// Self-checking testbench for the liquidity and latency based gateway route selector.
`timescale 1ns / 1ps
module liquidity_latency_route_select_tb;

    localparam int CMP_W = llrs_pkg::PROD_W + 1;

    typedef struct {
        logic [llrs_pkg::GW_W-1:0]  gw;
        logic                       routed;
        logic [llrs_pkg::TAG_W-1:0] tag;
        logic [llrs_pkg::CNT_W-1:0] total;
    } t_route_result;

    // Tracks the gateway tables and predicts each routing decision.
    class route_scoreboard;
        logic [llrs_pkg::DEPTH_W-1:0] depth_tab[llrs_pkg::NUM_GATEWAYS];
        logic [llrs_pkg::RTT_W-1:0]   rtt_tab[llrs_pkg::NUM_GATEWAYS];
        logic                         link_tab[llrs_pkg::NUM_GATEWAYS];
        logic [llrs_pkg::CNT_W-1:0]   drops;
        t_route_result                pending_routes[$];
        int errors;
        int shown;
        int n_depth, n_link, n_noop, n_routed, n_dropped;

        function new();
            for (int g = 0; g < llrs_pkg::NUM_GATEWAYS; g++) begin
                depth_tab[g] = llrs_pkg::DEPTH_W'(1);
                rtt_tab[g]   = '0;
                link_tab[g]  = 1'b0;
            end
            drops = '0;
        endfunction

        function int pending();
            return pending_routes.size();
        endfunction

        // Exact score compare: depth_i * rtt_b against depth_b * rtt_i.
        function bit outscores(int i, int b);
            logic [CMP_W-1:0] di, db, ri, rb;
            di = CMP_W'(depth_tab[i]);
            db = CMP_W'(depth_tab[b]);
            ri = CMP_W'(llrs_pkg::eff_rtt(rtt_tab[i]));
            rb = CMP_W'(llrs_pkg::eff_rtt(rtt_tab[b]));
            return (di * rb) > (db * ri);
        endfunction

        function void note_input(llrs_pkg::t_op op, llrs_pkg::t_s_data d);
            t_route_result r;
            bit found;
            int best;
            case (op)
                llrs_pkg::OP_DEPTH: begin
                    n_depth++;
                    if (d.depth[llrs_pkg::IN_DEPTH_W-1] || d.depth == '0)
                        depth_tab[d.gateway] = llrs_pkg::DEPTH_W'(1);
                    else
                        depth_tab[d.gateway] = d.depth[llrs_pkg::DEPTH_W-1:0];
                end
                llrs_pkg::OP_LINK: begin
                    n_link++;
                    rtt_tab[d.gateway]  = d.rtt_ns;
                    link_tab[d.gateway] = d.link_up;
                end
                llrs_pkg::OP_ROUTE: begin
                    found = 1'b0;
                    best  = 0;
                    for (int g = 0; g < llrs_pkg::NUM_GATEWAYS; g++) begin
                        if (link_tab[g] && (!found || outscores(g, best))) begin
                            best  = g;
                            found = 1'b1;
                        end
                    end
                    if (!found && drops != '1)
                        drops++;
                    if (found) n_routed++; else n_dropped++;
                    r.gw     = found ? llrs_pkg::GW_W'(best) : '0;
                    r.routed = found;
                    r.tag    = d.order_tag;
                    r.total  = drops;
                    pending_routes.push_back(r);
                end
                default: n_noop++;
            endcase
        endfunction

        function void check_result(llrs_pkg::t_m_data got, logic got_routed);
            t_route_result e;
            if (pending_routes.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("Unexpected result transfer: gw %0d routed %0b tag %h total %0d",
                             got.chosen_gateway, got_routed, got.order_tag_out,
                             got.dropped_total);
                end
                return;
            end
            e = pending_routes.pop_front();
            if (got.chosen_gateway !== e.gw || got_routed !== e.routed ||
                got.order_tag_out !== e.tag || got.dropped_total !== e.total) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("Mismatch: expected gw %0d routed %0b tag %h total %0d",
                             e.gw, e.routed, e.tag, e.total);
                    $display("          actual   gw %0d routed %0b tag %h total %0d",
                             got.chosen_gateway, got_routed, got.order_tag_out,
                             got.dropped_total);
                end
            end
        endfunction
    endclass

    logic                           i_clk    = 1'b0;
    logic                           i_rst_n  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    // gateway, depth, rtt_ns, link_up, order_tag
    logic [llrs_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [llrs_pkg::OP_W-1:0]      s_tuser  = '0;  // op
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    // chosen_gateway, order_tag_out, dropped_total
    logic [llrs_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;        // routed

    route_scoreboard sb;
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    bit  hold_rx = 1'b0;

    liquidity_latency_route_select dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_tready <= hold_rx ? 1'b0 : ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_result(llrs_pkg::t_m_data'(m_tdata), m_tuser);
    end

    function automatic llrs_pkg::t_s_data rand_payload();
        llrs_pkg::t_s_data d;
        logic [63:0] w;
        w           = {$urandom(), $urandom()};
        d.pad       = '0;
        d.gateway   = llrs_pkg::GW_W'($urandom_range(0, llrs_pkg::NUM_GATEWAYS - 1));
        d.depth     = w[llrs_pkg::IN_DEPTH_W-1:0];
        d.rtt_ns    = $urandom();
        d.link_up   = 1'($urandom_range(0, 1));
        d.order_tag = $urandom();
        return d;
    endfunction

    // Small values make ties and equal products likely; the rest reach the extremes.
    function automatic logic [llrs_pkg::IN_DEPTH_W-1:0] pick_depth();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        case ($urandom_range(0, 4))
            0: return w[llrs_pkg::IN_DEPTH_W-1:0];
            1: return llrs_pkg::IN_DEPTH_W'($urandom_range(1, 16));
            2: return '0;
            3: return {1'b1, w[llrs_pkg::IN_DEPTH_W-2:0]};
            default: return $urandom_range(0, 1) ? {1'b0, {(llrs_pkg::IN_DEPTH_W-1){1'b1}}}
                                                 : {1'b0, w[llrs_pkg::IN_DEPTH_W-2:0]};
        endcase
    endfunction

    function automatic logic [llrs_pkg::RTT_W-1:0] pick_rtt();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return llrs_pkg::RTT_W'($urandom_range(1, 16));
            2: return $urandom();
            default: return '1;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send(llrs_pkg::t_op op, llrs_pkg::t_s_data d);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= op;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_input(op, d);
        @(negedge i_clk);
    endtask

    task automatic send_depth(int gw, logic [llrs_pkg::IN_DEPTH_W-1:0] depth);
        llrs_pkg::t_s_data d;
        d         = rand_payload();
        d.gateway = llrs_pkg::GW_W'(gw);
        d.depth   = depth;
        send(llrs_pkg::OP_DEPTH, d);
    endtask

    task automatic send_link(int gw, logic [llrs_pkg::RTT_W-1:0] rtt, logic up);
        llrs_pkg::t_s_data d;
        d         = rand_payload();
        d.gateway = llrs_pkg::GW_W'(gw);
        d.rtt_ns  = rtt;
        d.link_up = up;
        send(llrs_pkg::OP_LINK, d);
    endtask

    task automatic send_route(logic [llrs_pkg::TAG_W-1:0] tag);
        llrs_pkg::t_s_data d;
        d           = rand_payload();
        d.order_tag = tag;
        send(llrs_pkg::OP_ROUTE, d);
    endtask

    task automatic run_random(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 28)
                send_depth($urandom_range(0, llrs_pkg::NUM_GATEWAYS - 1), pick_depth());
            else if (r < 52)
                send_link($urandom_range(0, llrs_pkg::NUM_GATEWAYS - 1), pick_rtt(),
                          $urandom_range(0, 3) != 0);
            else if (r < 94)
                send_route($urandom());
            else if (r < 97)
                send(llrs_pkg::OP_NONE, rand_payload());
            else begin
                // Take every link down so that the next order is dropped.
                for (int g = 0; g < llrs_pkg::NUM_GATEWAYS; g++)
                    send_link(g, pick_rtt(), 1'b0);
                send_route($urandom());
            end
        end
    endtask

    // Stop sending and wait for every outstanding order to come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: drops with nothing connected, unused op, depth clamping,
        // unmeasured and maximum RTT, and ties resolved toward the lowest index.
        send_route('0);
        send_route('1);
        send(llrs_pkg::OP_NONE, rand_payload());
        send_link(0, '0, 1'b1);
        send_route(32'h0000_0001);
        send_link(7, '1, 1'b1);
        send_depth(7, {1'b0, {(llrs_pkg::IN_DEPTH_W-1){1'b1}}});
        send_route(32'h8000_0000);
        send_depth(3, '0);
        send_depth(4, {1'b1, {(llrs_pkg::IN_DEPTH_W-1){1'b0}}});
        send_depth(5, '1);
        send_depth(7, 48'd1);
        send_link(3, 32'd1, 1'b1);
        send_link(4, '0, 1'b1);
        send_link(5, 32'd1, 1'b1);
        send_route(32'h5555_AAAA);
        send_link(0, '0, 1'b0);
        send_route(32'hAAAA_5555);
        send_depth(6, {1'b0, {(llrs_pkg::IN_DEPTH_W-1){1'b1}}});
        send_link(6, 32'd1, 1'b1);
        send_route(32'h1234_5678);
        send_link(6, '1, 1'b1);
        send_route(32'h8765_4321);
        drain();

        run_random(200);
        // Long receiver hold-off while orders keep coming, so the input backs up.
        fork
            begin
                hold_rx = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_rx = 1'b0;
            end
        join_none
        run_random(25);
        drain();

        tx_idle_pct = 48;
        run_random(230);
        drain();

        tx_idle_pct  = 0;
        rx_stall_pct = 48;
        run_random(230);
        drain();

        tx_idle_pct  = 11;
        rx_stall_pct = 11;
        run_random(230);
        drain();

        $display("Run covered %0d depth updates, %0d link updates and %0d unused-op transfers,",
                 sb.n_depth, sb.n_link, sb.n_noop);
        $display("with %0d orders routed and %0d dropped under varied source and sink pacing.",
                 sb.n_routed, sb.n_dropped);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* liquidity_latency_route_select.f */
+incdir+rtl
rtl/llrs_pkg.sv
rtl/llrs_front.sv
rtl/llrs_fifo.sv
rtl/llrs_back.sv
rtl/liquidity_latency_route_select.sv
tb/sv/liquidity_latency_route_select_tb.sv
